// ===== rtl/core/hcis_pkg.sv =====
// Shared types, constants and field positions for the Hack instruction step block.
package hcis_pkg;

  // Default sizes of the data store and of the machine word.
  localparam int unsigned MEM_WORDS_DEF   = 32768;
  localparam int unsigned WORD_BITS_DEF   = 16;

  // Fixed field widths of the item formats.
  localparam int unsigned PC_BITS         = 15;
  localparam int unsigned CONST_BITS      = 15;
  localparam int unsigned FIELD_BITS      = 16;
  localparam int unsigned COMP_BITS       = 7;
  localparam int unsigned DEST_BITS       = 3;
  localparam int unsigned JUMP_BITS       = 3;
  localparam int unsigned ALU_CTRL_BITS   = 6;

  // Value of data word 0 after reset (the stack pointer's start).
  localparam int unsigned DATA_WORD0_INIT = 256;

  // Instruction kinds.
  localparam logic ACTION_LOAD_A  = 1'b0;
  localparam logic ACTION_COMPUTE = 1'b1;

  // Bit positions inside comp_code.
  localparam int unsigned COMP_SEL_M = 6;
  localparam int unsigned COMP_ZX    = 5;
  localparam int unsigned COMP_NX    = 4;
  localparam int unsigned COMP_ZY    = 3;
  localparam int unsigned COMP_NY    = 2;
  localparam int unsigned COMP_F     = 1;
  localparam int unsigned COMP_NO    = 0;

  // Bit positions inside dest_code.
  localparam int unsigned DEST_A = 2;
  localparam int unsigned DEST_D = 1;
  localparam int unsigned DEST_M = 0;

  // Bit positions inside jump_code.
  localparam int unsigned JUMP_LT = 2;
  localparam int unsigned JUMP_EQ = 1;
  localparam int unsigned JUMP_GT = 0;

  // One input beat.
  typedef struct packed {
    logic                  action;
    logic [CONST_BITS-1:0] constant_value;
    logic [COMP_BITS-1:0]  comp_code;
    logic [DEST_BITS-1:0]  dest_code;
    logic [JUMP_BITS-1:0]  jump_code;
  } in_t;

  // One result beat.
  typedef struct packed {
    logic [PC_BITS-1:0]           next_pc;
    logic                         jump_taken;
    logic signed [FIELD_BITS-1:0] alu_value;
    logic signed [FIELD_BITS-1:0] a_after;
    logic signed [FIELD_BITS-1:0] d_after;
  } out_t;

  // Status of one ALU evaluation.
  typedef struct packed {
    logic neg;
    logic zero;
    logic jump;
  } alu_status_t;

endpackage

// ===== rtl/core/hcis_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module hcis_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port; a read at the written address in the same cycle returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/hcis_alu.sv =====
// Hack ALU (zx nx zy ny f no) with the sign and zero jump test.
module hcis_alu #(
  parameter int unsigned WORD_BITS = hcis_pkg::WORD_BITS_DEF
) (
  input  logic [WORD_BITS-1:0]             x_i,
  input  logic [WORD_BITS-1:0]             y_i,
  input  logic [hcis_pkg::ALU_CTRL_BITS-1:0] ctrl_i,
  input  logic [hcis_pkg::JUMP_BITS-1:0]   jump_i,
  output logic [WORD_BITS-1:0]             result_o,
  output hcis_pkg::alu_status_t            status_o
);
  import hcis_pkg::*;

  logic [WORD_BITS-1:0] x_zero;
  logic [WORD_BITS-1:0] x_inv;
  logic [WORD_BITS-1:0] y_zero;
  logic [WORD_BITS-1:0] y_inv;
  logic [WORD_BITS-1:0] core;

  // Operand conditioning, function select and output inversion.
  always_comb begin
    x_zero   = ctrl_i[COMP_ZX] ? '0 : x_i;
    x_inv    = ctrl_i[COMP_NX] ? ~x_zero : x_zero;
    y_zero   = ctrl_i[COMP_ZY] ? '0 : y_i;
    y_inv    = ctrl_i[COMP_NY] ? ~y_zero : y_zero;
    core     = ctrl_i[COMP_F] ? (x_inv + y_inv) : (x_inv & y_inv);
    result_o = ctrl_i[COMP_NO] ? ~core : core;
  end

  // Jump condition on the sign and zero of the result.
  always_comb begin
    status_o.neg  = result_o[WORD_BITS-1];
    status_o.zero = (result_o == '0);
    status_o.jump = (jump_i[JUMP_LT] && status_o.neg)
                 || (jump_i[JUMP_EQ] && status_o.zero)
                 || (jump_i[JUMP_GT] && !status_o.neg && !status_o.zero);
  end

endmodule

// ===== rtl/core/hack_cpu_instruction_step_top.sv =====
// Hack CPU instruction step: one decoded instruction per input beat, one result beat each.
//
// The block executes one instruction per clock cycle unless the output register stalls or
// the clearing pass runs. Registers A, D and PC sit in flip-flops; the data memory is a
// RAM of MEM_WORDS words (a power of two) with a registered read. The read for an
// instruction is issued in the cycle it is accepted, at A as left by the instruction ahead
// of it, which is forwarded straight from the ALU; the loop from the memory's read register
// through the ALU to the next read address sets the clock period. A read that meets a
// write to the same word in the same cycle takes the written word from a bypass register.
// After reset the block clears the memory word by word (word 0 is set to 256) and holds
// in_ready_o low until that pass is done. Results wait in an output register, so a new
// instruction is taken while a finished result still waits for out_ready_i.
module hack_cpu_instruction_step_top #(
  parameter int unsigned MEM_WORDS = hcis_pkg::MEM_WORDS_DEF,
  parameter int unsigned WORD_BITS = hcis_pkg::WORD_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hcis_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hcis_pkg::out_t out_o
);
  import hcis_pkg::*;

  localparam int unsigned AddrBits = $clog2(MEM_WORDS);
  localparam logic [AddrBits-1:0] LastAddr = AddrBits'(MEM_WORDS - 1);

  // Architectural registers.
  logic [WORD_BITS-1:0] a_q, a_d;
  logic [WORD_BITS-1:0] d_q, d_d;
  logic [PC_BITS-1:0]   pc_q, pc_d;

  // Execute stage.
  logic                 s1_valid_q;
  in_t                  s1_item_q;
  logic                 s1_fire;
  logic                 in_fire;

  // Memory bypass.
  logic                 fwd_q, fwd_d;
  logic [WORD_BITS-1:0] fwd_data_q;

  // Output register.
  logic                 out_valid_q;
  out_t                 out_q, out_d;

  // Clearing pass.
  logic                 clr_busy_q;
  logic [AddrBits-1:0]  clr_addr_q;

  // RAM ports.
  logic                 ram_we;
  logic [AddrBits-1:0]  ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AddrBits-1:0]  ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // Datapath.
  logic                 is_compute;
  logic [WORD_BITS-1:0] m_val;
  logic [WORD_BITS-1:0] y_val;
  logic [WORD_BITS-1:0] alu_result;
  alu_status_t          alu_status;
  logic                 taken;
  logic [WORD_BITS-1:0] val;
  logic                 exec_mem_we;
  logic [WORD_BITS-1:0] a_fwd;

  // Handshake.
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr_busy_q && (!s1_valid_q || s1_fire);
  assign in_fire    = in_valid_i && in_ready_o;

  // Operand selection; M comes from the bypass when the last write hit this word.
  assign is_compute = (s1_item_q.action == ACTION_COMPUTE);
  assign m_val      = fwd_q ? fwd_data_q : ram_rdata;
  assign y_val      = s1_item_q.comp_code[COMP_SEL_M] ? m_val : a_q;

  hcis_alu #(
    .WORD_BITS(WORD_BITS)
  ) u_alu (
    .x_i     (d_q),
    .y_i     (y_val),
    .ctrl_i  (s1_item_q.comp_code[ALU_CTRL_BITS-1:0]),
    .jump_i  (s1_item_q.jump_code),
    .result_o(alu_result),
    .status_o(alu_status)
  );

  // Next architectural state of the instruction in the execute stage.
  always_comb begin
    taken = is_compute && alu_status.jump;
    val   = is_compute ? alu_result : '0;
    pc_d  = taken ? a_q[PC_BITS-1:0] : (pc_q + PC_BITS'(1));
    if (!is_compute) begin
      a_d = WORD_BITS'(s1_item_q.constant_value);
    end else if (s1_item_q.dest_code[DEST_A]) begin
      a_d = alu_result;
    end else begin
      a_d = a_q;
    end
    d_d = (is_compute && s1_item_q.dest_code[DEST_D]) ? alu_result : d_q;
    exec_mem_we = s1_fire && is_compute && s1_item_q.dest_code[DEST_M];
  end

  // A seen by the instruction being accepted, forwarded from the one retiring now.
  assign a_fwd     = s1_fire ? a_d : a_q;
  assign ram_raddr = a_fwd[AddrBits-1:0];
  assign fwd_d     = exec_mem_we && (a_q[AddrBits-1:0] == ram_raddr);

  // Write port: the clearing pass owns it after reset, the execute stage afterwards.
  always_comb begin
    if (clr_busy_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = (clr_addr_q == '0) ? WORD_BITS'(DATA_WORD0_INIT) : '0;
    end else begin
      ram_we    = exec_mem_we;
      ram_waddr = a_q[AddrBits-1:0];
      ram_wdata = alu_result;
    end
  end

  hcis_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MEM_WORDS)
  ) u_data_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (in_fire),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Result beat of the retiring instruction.
  always_comb begin
    out_d.next_pc    = pc_d;
    out_d.jump_taken = taken;
    out_d.alu_value  = val[FIELD_BITS-1:0];
    out_d.a_after    = a_d[FIELD_BITS-1:0];
    out_d.d_after    = d_d[FIELD_BITS-1:0];
  end

  // Control state and architectural registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q         <= '0;
      d_q         <= '0;
      pc_q        <= '0;
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + AddrBits'(1);
        if (clr_addr_q == LastAddr) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (s1_fire) begin
        a_q  <= a_d;
        d_q  <= d_d;
        pc_q <= pc_d;
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= fwd_d;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q  <= in_i;
      fwd_data_q <= alu_result;
    end
    if (s1_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/core/hcis_checker.sv =====
// Port-level checks for the Hack instruction step block, bound to its top level.
module hcis_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input hcis_pkg::out_t out_o
);
  import hcis_pkg::*;

  // A stalled result beat stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result beat dropped or changed while stalled");

  // Back-to-back results without a jump step the program counter by one.
  a_pc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i ##1 out_valid_o && !out_o.jump_taken
    |-> out_o.next_pc == $past(out_o.next_pc) + PC_BITS'(1))
    else $error("next_pc did not advance by one");

  // A taken jump goes to the A left by the previous instruction.
  a_jump_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i ##1 out_valid_o && out_o.jump_taken
    |-> out_o.next_pc == $past(out_o.a_after[PC_BITS-1:0]))
    else $error("jump target differs from A");

  // In the first cycle after reset is released the memory is being cleared: no beats.
  a_reset_quiet: assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> !in_ready_o && !out_valid_o)
    else $error("block active right after reset");

  // While the block is ready, the input valid must be a known value.
  a_in_valid_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !$isunknown(in_valid_i))
    else $error("input valid unknown while ready");

endmodule

bind hack_cpu_instruction_step_top hcis_checker u_hcis_checker (.*);
